@@ hw/rtl/hrs_pkg.sv @@
`default_nettype none
package hrs_pkg;

  // Ring geometry
  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int PTR_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int SUM_W      = PTR_W + 2;

  // Request and response field widths
  localparam int POS_W   = 4;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;
  localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef logic [PTR_W-1:0]      ptr_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [SUM_W-1:0]      sum_t;
  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [POS_W-1:0]      pos_t;
  typedef logic [VALUE_W-1:0]    value_t;
  typedef logic [COUNT_W-1:0]    count_t;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_READ   = 2'd1,
    OP_DELETE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_DONE
  } state_t;

  function automatic ptr_t ptr_next(input ptr_t p);
    return (p == ptr_t'(DEPTH - 1)) ? '0 : ptr_t'(p + 1'b1);
  endfunction

  function automatic ptr_t ptr_prev(input ptr_t p);
    return (p == '0) ? ptr_t'(DEPTH - 1) : ptr_t'(p - 1'b1);
  endfunction

  // Fold a sum below twice DEPTH back into the ring
  function automatic ptr_t ptr_wrap(input sum_t s);
    return (s >= sum_t'(DEPTH)) ? ptr_t'(s - sum_t'(DEPTH)) : ptr_t'(s);
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/hrs_in_if.sv @@
`default_nettype none
interface hrs_in_if;
  import hrs_pkg::*;

  logic   valid;
  logic   ready;
  op_t    operation;
  pos_t   position;
  value_t entry_value;

  modport source (output valid, output operation, output position, output entry_value,
                  input ready);
  modport sink   (input valid, input operation, input position, input entry_value,
                  output ready);
endinterface
`default_nettype wire

@@ hw/rtl/hrs_out_if.sv @@
`default_nettype none
interface hrs_out_if;
  import hrs_pkg::*;

  logic   valid;
  logic   ready;
  value_t read_value;
  count_t entry_count;
  logic   index_error;

  modport source (output valid, output read_value, output entry_count, output index_error,
                  input ready);
  modport sink   (input valid, input read_value, input entry_count, input index_error,
                  output ready);
endinterface
`default_nettype wire

@@ hw/rtl/hrs_ram.sv @@
`default_nettype none
module hrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/history_ring_store.sv @@
`default_nettype none
// Channel   Dir  Handshake     Payload
// in_req    in   valid/ready   operation, position, entry_value
// out_rsp   out  valid/ready   read_value, entry_count, index_error
//
// Push, clear, bad-index requests and reads pass from IDLE to DONE, then into the result register.
// Delete at position p of n entries moves n - p - 1 words: straight to DONE when none move,
// else through SHIFT (one read per moved word, a final write) and then DONE for the result.
// The longest shift, a delete at position 0 of a full ring, moves DEPTH - 1 words.
// Reset (rst_n low, synchronous) empties the ring and zeroes the pointer.
// in_req.ready is low while a request is in work; an unaccepted result holds the block.
module history_ring_store (
  input  wire logic clk,
  input  wire logic rst_n,
  hrs_in_if.sink    in_req,
  hrs_out_if.source out_rsp
);
  import hrs_pkg::*;

  // Live entries always form one contiguous run ending just below the
  // write pointer, so a count stands in for the per-slot valid marks.
  state_t state_r, state_nxt;
  ptr_t   wp_r, wp_nxt;
  cnt_t   cnt_r, cnt_nxt;
  ptr_t   rd_ptr_r, rd_ptr_nxt;   // next slot to read during a shift
  ptr_t   wr_ptr_r, wr_ptr_nxt;   // destination of the word arriving this cycle
  ptr_t   left_r, left_nxt;       // reads still to issue during a shift
  logic   arr_r, arr_nxt;         // RAM output carries a word to move
  logic   hit_r, hit_nxt;         // result carries RAM read data
  logic   err_r, err_nxt;

  logic   out_valid_r, out_valid_nxt;
  value_t out_value_r, out_value_nxt;
  count_t out_count_r, out_count_nxt;
  logic   out_err_r, out_err_nxt;

  logic   ram_we, ram_re;
  ptr_t   ram_waddr, ram_raddr;
  data_t  ram_wdata, ram_rdata;

  logic   bad_pos;
  ptr_t   oldest, target;
  cnt_t   moves;

  hrs_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Oldest live slot is the pointer minus the count, with wrap
  assign oldest  = ptr_wrap(sum_t'(wp_r) + sum_t'(DEPTH) - sum_t'(cnt_r));
  assign target  = ptr_wrap(sum_t'(oldest) + sum_t'(ptr_t'(in_req.position)));
  assign bad_pos = CMP_W'(in_req.position) >= CMP_W'(cnt_r);
  assign moves   = cnt_t'(cnt_r - cnt_t'(1) - cnt_t'(in_req.position));

  assign in_req.ready        = (state_r == ST_IDLE);
  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.read_value  = out_value_r;
  assign out_rsp.entry_count = out_count_r;
  assign out_rsp.index_error = out_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wp_r        <= '0;
      cnt_r       <= '0;
      arr_r       <= 1'b0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      cnt_r       <= cnt_nxt;
      arr_r       <= arr_nxt;
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr_r    <= rd_ptr_nxt;
    wr_ptr_r    <= wr_ptr_nxt;
    hit_r       <= hit_nxt;
    err_r       <= err_nxt;
    out_value_r <= out_value_nxt;
    out_count_r <= out_count_nxt;
    out_err_r   <= out_err_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    cnt_nxt       = cnt_r;
    rd_ptr_nxt    = rd_ptr_r;
    wr_ptr_nxt    = wr_ptr_r;
    left_nxt      = left_r;
    arr_nxt       = arr_r;
    hit_nxt       = hit_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && !out_rsp.ready;
    out_value_nxt = out_value_r;
    out_count_nxt = out_count_r;
    out_err_nxt   = out_err_r;
    ram_we        = 1'b0;
    ram_waddr     = wp_r;
    ram_wdata     = data_t'(in_req.entry_value);
    ram_re        = 1'b0;
    ram_raddr     = rd_ptr_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_req.valid) begin
          hit_nxt   = 1'b0;
          err_nxt   = 1'b0;
          arr_nxt   = 1'b0;
          state_nxt = ST_DONE;
          unique case (in_req.operation)
            OP_PUSH: begin
              // Overwrite the oldest entry once the ring is full
              ram_we = 1'b1;
              wp_nxt = ptr_next(wp_r);
              if (cnt_r != cnt_t'(DEPTH)) begin
                cnt_nxt = cnt_t'(cnt_r + 1'b1);
              end
            end
            OP_READ: begin
              if (bad_pos) begin
                err_nxt = 1'b1;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = target;
                hit_nxt   = 1'b1;
              end
            end
            OP_DELETE: begin
              if (bad_pos) begin
                err_nxt = 1'b1;
              end else begin
                // Later entries move down one slot; the top slot drops out
                cnt_nxt    = cnt_t'(cnt_r - 1'b1);
                wp_nxt     = ptr_prev(wp_r);
                rd_ptr_nxt = ptr_next(target);
                left_nxt   = ptr_t'(moves);
                if (moves != '0) begin
                  state_nxt = ST_SHIFT;
                end
              end
            end
            OP_CLEAR: begin
              cnt_nxt = '0;
              wp_nxt  = '0;
            end
            default: ;
          endcase
        end
      end

      ST_SHIFT: begin
        // Read the next word while writing the previous one a slot lower
        ram_re     = (left_r != '0);
        ram_raddr  = rd_ptr_r;
        ram_we     = arr_r;
        ram_waddr  = wr_ptr_r;
        ram_wdata  = ram_rdata;
        arr_nxt    = (left_r != '0);
        wr_ptr_nxt = ptr_prev(rd_ptr_r);
        rd_ptr_nxt = ptr_next(rd_ptr_r);
        if (left_r != '0) begin
          left_nxt = ptr_t'(left_r - 1'b1);
        end else begin
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        // Hold until the response register is free
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = hit_r ? value_t'(ram_rdata) : '0;
          out_count_nxt = count_t'(cnt_r);
          out_err_nxt   = err_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= cnt_t'(DEPTH))
    else $error("entry count above ring depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    in_req.valid && in_req.ready && in_req.operation == OP_PUSH && cnt_r != cnt_t'(DEPTH)
    |=> cnt_r == cnt_t'($past(cnt_r) + 1'b1))
    else $error("push below full did not add an entry");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    in_req.valid && in_req.ready && in_req.operation == OP_CLEAR
    |=> cnt_r == '0 && wp_r == '0)
    else $error("clear left entries or pointer");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_err_r |-> out_value_r == '0)
    else $error("index error with nonzero read data");

  a_shift_ports: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SHIFT && ram_we && ram_re |-> ram_waddr != ram_raddr)
    else $error("shift writes the slot it reads");

endmodule
`default_nettype wire

@@ bench/hrs_ring_checker.sv @@
module hrs_ring_checker (
  input  logic clk,
  input  logic rst_n,
  hrs_in_if    req_mon,
  hrs_out_if   rsp_mon,
  output int   fail_count,
  output int   pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import hrs_pkg::*;

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    value_t read_value;
    count_t entry_count;
    logic   index_error;
  } ring_rsp_t;

  // Shadow copy of the ring
  data_t     slot_word [DEPTH];
  logic      slot_live [DEPTH];
  int        head_slot = 0;
  ring_rsp_t awaited_rsp [$];
  int        fail_total = 0;
  int        rsp_seen = 0;
  int        awaited_total = 0;

  assign fail_count    = fail_total;
  assign pending_count = awaited_total;

  function automatic int live_total();
    int n = 0;
    for (int i = 0; i < DEPTH; i++) if (slot_live[i]) n++;
    return n;
  endfunction

  // Slot of the pos-th live entry, scanning upward from the write slot
  function automatic int find_slot(int pos);
    int s;
    int seen;
    s    = head_slot;
    seen = 0;
    for (int k = 0; k < DEPTH; k++) begin
      if (slot_live[s]) begin
        if (seen == pos) return s;
        seen++;
      end
      s = (s + 1) % DEPTH;
    end
    return head_slot;
  endfunction

  function automatic ring_rsp_t apply_request(op_t op, pos_t pos, value_t val);
    ring_rsp_t rsp;
    int        live;
    int        s;
    int        t;
    rsp  = '0;
    live = live_total();
    case (op)
      OP_PUSH: begin
        slot_word[head_slot] = data_t'(val);
        slot_live[head_slot] = 1'b1;
        head_slot = (head_slot + 1) % DEPTH;
      end
      OP_READ: begin
        if (int'(pos) >= live) rsp.index_error = 1'b1;
        else rsp.read_value = value_t'(slot_word[find_slot(int'(pos))]);
      end
      OP_DELETE: begin
        if (int'(pos) >= live) begin
          rsp.index_error = 1'b1;
        end else begin
          // close the gap: pull every younger entry down one slot
          s = (find_slot(0) + int'(pos)) % DEPTH;
          for (int k = int'(pos); k + 1 < live; k++) begin
            t = (s + 1) % DEPTH;
            slot_word[s] = slot_word[t];
            slot_live[s] = slot_live[t];
            s = t;
          end
          slot_live[s] = 1'b0;
          head_slot = (head_slot == 0) ? DEPTH - 1 : head_slot - 1;
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < DEPTH; i++) slot_live[i] = 1'b0;
        head_slot = 0;
      end
    endcase
    rsp.entry_count = count_t'(live_total());
    return rsp;
  endfunction

  always @(posedge clk) begin
    ring_rsp_t got;
    ring_rsp_t want;
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        slot_live[i] = 1'b0;
        slot_word[i] = '0;
      end
      head_slot = 0;
      awaited_rsp.delete();
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        got = '{rsp_mon.read_value, rsp_mon.entry_count, rsp_mon.index_error};
        rsp_seen++;
        if (awaited_rsp.size() == 0) begin
          fail_total++;
          if (fail_total <= MAX_REPORTS)
            $display("checker: response %0d with none awaited: value %h count %0d err %b",
                     rsp_seen, got.read_value, got.entry_count, got.index_error);
        end else begin
          want = awaited_rsp.pop_front();
          if (got !== want) begin
            fail_total++;
            if (fail_total <= MAX_REPORTS)
              $display(
                "checker: rsp %0d mismatch: expected value %h count %0d err %b, got %h %0d %b",
                rsp_seen, want.read_value, want.entry_count, want.index_error,
                got.read_value, got.entry_count, got.index_error);
          end
        end
      end
      if (req_mon.valid && req_mon.ready)
        awaited_rsp.push_back(apply_request(req_mon.operation, req_mon.position,
                                            req_mon.entry_value));
    end
    awaited_total = awaited_rsp.size();
  end

endmodule

@@ bench/tb_history_ring_store.sv @@
module tb_history_ring_store;
  timeunit 1ns;
  timeprecision 1ps;
  import hrs_pkg::*;

  localparam int RANDOM_ITEMS = 800;
  localparam int CYCLE_LIMIT  = 300_000;
  // Receiver hold-off, long enough to back the block up onto its input
  localparam int LONG_HOLD    = 120;
  // Settling wait after the last response, longer than the worst delete
  localparam int SETTLE       = DEPTH + 4;

  // Receiver pacing styles
  typedef enum int {
    DRAIN_FREE,
    DRAIN_COIN,
    DRAIN_SPARSE
  } drain_mode_t;

  logic clk = 1'b0;
  logic rst_n;

  hrs_in_if  in_req ();
  hrs_out_if out_rsp ();

  int checker_fails;
  int responses_due;
  int cycle_count = 0;

  // Handshake between the stimulus and the receiver for the long hold-off
  int holds_asked = 0;
  int holds_done  = 0;

  // Stimulus bookkeeping
  int op_tally [4];
  int bad_index_sent = 0;
  int sent_total = 0;
  int ring_fill = 0;   // entries the ring should hold, used to aim positions
  int burst_left = 0;

  history_ring_store u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  hrs_ring_checker u_ring_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_mon       (in_req),
    .rsp_mon       (out_rsp),
    .fail_count    (checker_fails),
    .pending_count (responses_due)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Bound the run; a hang anywhere ends here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles, %0d responses outstanding",
               cycle_count, responses_due);
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver: switch between pacing styles at random intervals, and hold
  // ready low for a long stretch whenever the stimulus asks for it.
  initial begin : rsp_pacing
    drain_mode_t mode;
    int          mode_left;
    int          hold_left;
    mode      = DRAIN_FREE;
    mode_left = 0;
    hold_left = 0;
    out_rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done != holds_asked) begin
        holds_done = holds_asked;
        hold_left  = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_rsp.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = drain_mode_t'($urandom_range(0, 2));
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        case (mode)
          DRAIN_FREE:   out_rsp.ready <= 1'b1;
          DRAIN_COIN:   out_rsp.ready <= 1'($urandom_range(0, 1));
          DRAIN_SPARSE: out_rsp.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Drop valid for a number of cycles
  task automatic pause_sender(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_req.valid <= 1'b0;
    end
  endtask

  // Drop valid and hold off until every outstanding response is back
  task automatic drain_sender();
    @(negedge clk);
    in_req.valid <= 1'b0;
    while (responses_due != 0) @(negedge clk);
  endtask

  // Offer one request and hold it until accepted. Valid stays high on return
  // so the next request can follow back to back inside a burst.
  task automatic offer(op_t op, pos_t pos, value_t val);
    if (burst_left == 0) begin
      pause_sender($urandom_range(1, 8));
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    in_req.valid       <= 1'b1;
    in_req.operation   <= op;
    in_req.position    <= pos;
    in_req.entry_value <= val;
    do @(posedge clk); while (!in_req.ready);
    // track the expected fill so later positions land mostly in range
    op_tally[op]++;
    sent_total++;
    case (op)
      OP_PUSH:   if (ring_fill < DEPTH) ring_fill++;
      OP_READ:   if (int'(pos) >= ring_fill) bad_index_sent++;
      OP_DELETE: begin
        if (int'(pos) >= ring_fill) bad_index_sent++;
        else ring_fill--;
      end
      OP_CLEAR:  ring_fill = 0;
    endcase
  endtask

  // Data word with the extremes weighted in
  function automatic value_t pick_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return value_t'($urandom);
    endcase
  endfunction

  // Mostly a live position; now and then anything the field allows
  function automatic pos_t pick_position();
    if (ring_fill == 0 || $urandom_range(0, 7) == 0) return pos_t'($urandom_range(0, 15));
    return pos_t'($urandom_range(0, ring_fill - 1));
  endfunction

  // Fill the ring (often past full, so pushes overwrite), then probe it
  task automatic fill_and_probe();
    if ($urandom_range(0, 1)) offer(OP_CLEAR, pick_position(), pick_word());
    repeat ($urandom_range(DEPTH - 3, DEPTH + 5)) offer(OP_PUSH, pick_position(), pick_word());
    // the newest slot and a delete from the front, the longest shift
    offer(OP_READ, pos_t'(DEPTH - 1), pick_word());
    offer(OP_DELETE, '0, pick_word());
    repeat ($urandom_range(4, 12))
      offer($urandom_range(0, 1) ? OP_READ : OP_DELETE, pick_position(), pick_word());
  endtask

  // Weighted mix of all four operations, mostly on live positions
  task automatic mixed_requests();
    op_t op;
    int  roll;
    repeat ($urandom_range(8, 20)) begin
      roll = $urandom_range(0, 99);
      if (roll < 38)      op = OP_PUSH;
      else if (roll < 70) op = OP_READ;
      else if (roll < 97) op = OP_DELETE;
      else                op = OP_CLEAR;
      offer(op, pick_position(), pick_word());
    end
  endtask

  // Anything at all
  task automatic noise_requests();
    repeat ($urandom_range(4, 10))
      offer(op_t'($urandom_range(0, 3)), pos_t'($urandom_range(0, 15)), pick_word());
  endtask

  initial begin : stimulus
    int  random_goal;
    bit  held;
    bit  drained;
    held    = 1'b0;
    drained = 1'b0;
    foreach (op_tally[i]) op_tally[i] = 0;

    rst_n              = 1'b0;
    in_req.valid       = 1'b0;
    in_req.operation   = OP_PUSH;
    in_req.position    = '0;
    in_req.entry_value = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty ring: read and delete are out of range, clear is harmless
    offer(OP_READ,   4'h0, 32'h0000_0000);
    offer(OP_DELETE, 4'hF, 32'hFFFF_FFFF);
    offer(OP_CLEAR,  4'h0, 32'h0000_0000);
    // Extreme words, then reads at the front, the back and one past the end
    offer(OP_PUSH,   4'h0, 32'h0000_0000);
    offer(OP_PUSH,   4'hF, 32'hFFFF_FFFF);
    offer(OP_PUSH,   4'h0, 32'h8000_0001);
    offer(OP_READ,   4'h0, 32'hFFFF_FFFF);
    offer(OP_READ,   4'h2, 32'h0000_0000);
    offer(OP_READ,   4'h3, 32'h0000_0000);
    // Delete from the middle, then check the shifted entry
    offer(OP_DELETE, 4'h1, 32'h0000_0000);
    offer(OP_READ,   4'h1, 32'h0000_0000);
    // Delete at the count, then the last and the only entry
    offer(OP_DELETE, 4'h2, 32'h0000_0000);
    offer(OP_DELETE, 4'h1, 32'h0000_0000);
    offer(OP_DELETE, 4'h0, 32'h0000_0000);
    offer(OP_PUSH,   4'h0, 32'h1234_5678);
    offer(OP_CLEAR,  4'hF, 32'hFFFF_FFFF);
    offer(OP_READ,   4'h0, 32'h0000_0000);

    random_goal = sent_total + RANDOM_ITEMS;
    fill_and_probe();
    while (sent_total < random_goal) begin
      // Stall the receiver and keep offering with no gaps: the block backs up
      if (!held && sent_total >= random_goal - 500) begin
        holds_asked++;
        burst_left = 48;
        held = 1'b1;
      end
      // Let everything drain once mid-run
      if (!drained && sent_total >= random_goal - 250) begin
        drain_sender();
        drained = 1'b1;
      end
      case ($urandom_range(0, 9))
        0, 1, 2: fill_and_probe();
        8, 9:    noise_requests();
        default: mixed_requests();
      endcase
    end

    @(negedge clk);
    in_req.valid <= 1'b0;
    while (responses_due != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);

    $display("run covered %0d requests: %0d push, %0d read, %0d delete, %0d clear",
             sent_total, op_tally[OP_PUSH], op_tally[OP_READ], op_tally[OP_DELETE],
             op_tally[OP_CLEAR]);
    $display("run covered %0d out-of-range positions, %0d mismatches in %0d cycles",
             bad_index_sent, checker_fails, cycle_count);
    if (checker_fails == 0 && responses_due == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/hrs_pkg.sv
hw/rtl/hrs_in_if.sv
hw/rtl/hrs_out_if.sv
hw/rtl/hrs_ram.sv
hw/rtl/history_ring_store.sv
bench/hrs_ring_checker.sv
bench/tb_history_ring_store.sv
